// File: rtl/sip_pkg.sv
`timescale 1ns / 1ps

package sip_pkg;

	localparam int POOL_BYTES   = 65536;
	localparam int MAX_NAME_LEN = 63;

	localparam int POOL_AW = $clog2(POOL_BYTES);
	localparam int FILL_W  = POOL_AW + 1;
	localparam int STG_AW  = $clog2(MAX_NAME_LEN);
	localparam int LEN_W   = $clog2(MAX_NAME_LEN + 1);
	localparam int OFF_W   = 16;
	localparam int CALC_W  = 17;

	localparam logic [OFF_W-1:0] NONE_OFFSET = 16'hFFFF;

	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] ST_FOUND    = 2'd0;
	localparam logic [1:0] ST_ADDED    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_TOO_LONG = 2'd3;

	typedef struct packed {
		logic               re;
		logic               we;
		logic [POOL_AW-1:0] addr;
		logic [7:0]         wdata;
	} pool_req_t;

	typedef struct packed {
		logic              re;
		logic              we;
		logic [STG_AW-1:0] addr;
		logic [7:0]        wdata;
	} stg_req_t;

	typedef struct packed {
		logic [OFF_W-1:0] offset;
		logic [1:0]       status;
		logic [7:0]       read_char;
		logic             char_valid;
		logic             last;
	} result_t;

endpackage

// File: rtl/sip_ram.sv
`timescale 1ns / 1ps

module sip_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// File: rtl/sip_outreg.sv
`timescale 1ns / 1ps

module sip_outreg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  sip_pkg::result_t res,
	output logic             can_load,
	output logic             out_valid,
	input  logic             out_ready,
	output sip_pkg::result_t res_q
);

	assign can_load = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (can_load) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			res_q <= res;
		end
	end

endmodule

// File: rtl/sip_ctrl.sv
`timescale 1ns / 1ps

module sip_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           operation,
	input  logic [7:0]           character,
	input  logic                 end_of_name,
	input  logic [15:0]          read_offset,
	output sip_pkg::pool_req_t   pool_req,
	input  logic [7:0]           pool_rdata,
	output sip_pkg::stg_req_t    stg_req,
	input  logic [7:0]           stg_rdata,
	input  logic                 can_emit,
	output logic                 emit,
	output sip_pkg::result_t     res
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SCAN_RD  = 3'd1;
	localparam logic [2:0] S_SCAN_CMP = 3'd2;
	localparam logic [2:0] S_APP_RD   = 3'd3;
	localparam logic [2:0] S_APP_WR   = 3'd4;
	localparam logic [2:0] S_RESULT   = 3'd5;
	localparam logic [2:0] S_RD_CHK   = 3'd6;
	localparam logic [2:0] S_RD_LAST  = 3'd7;

	logic [2:0]                     state_q, state_d;
	logic [sip_pkg::FILL_W-1:0]     fill_q, fill_d;
	logic [sip_pkg::LEN_W-1:0]      len_q, len_d;
	logic                           ovf_q, ovf_d;
	logic [sip_pkg::FILL_W-1:0]     ptr_q, ptr_d;
	logic [sip_pkg::LEN_W-1:0]      k_q, k_d;
	logic                           match_q, match_d;
	logic [sip_pkg::POOL_AW-1:0]    entry_q, entry_d;
	logic [sip_pkg::OFF_W-1:0]      res_off_q, res_off_d;
	logic [1:0]                     res_st_q, res_st_d;
	logic                           res_clr_q, res_clr_d;
	logic [sip_pkg::LEN_W-1:0]      n_q, n_d;
	logic [7:0]                     pend_q, pend_d;
	logic                           pend_vld_q, pend_vld_d;

	logic                           accept;
	logic                           ovf_next;
	logic [sip_pkg::FILL_W-1:0]     ptr_inc;
	logic [sip_pkg::LEN_W-1:0]      n_inc;
	logic [sip_pkg::CALC_W-1:0]     need_end;
	logic                           no_room;
	logic                           read_empty;

	assign in_ready   = (state_q == S_IDLE);
	assign accept     = in_valid && in_ready;
	assign ovf_next   = ovf_q || ((character != 8'd0) &&
		(len_q == sip_pkg::LEN_W'(sip_pkg::MAX_NAME_LEN)));
	assign ptr_inc    = ptr_q + sip_pkg::FILL_W'(1);
	assign n_inc      = n_q + sip_pkg::LEN_W'(1);
	assign need_end   = sip_pkg::CALC_W'(fill_q) + sip_pkg::CALC_W'(len_q)
		+ sip_pkg::CALC_W'(1);
	assign no_room    = (sip_pkg::CALC_W'(fill_q) >= sip_pkg::CALC_W'(sip_pkg::NONE_OFFSET))
		|| (need_end > sip_pkg::CALC_W'(sip_pkg::POOL_BYTES));
	assign read_empty = (read_offset == sip_pkg::NONE_OFFSET) || (fill_q == '0)
		|| (sip_pkg::CALC_W'(read_offset) >= sip_pkg::CALC_W'(fill_q));

	always_comb begin
		state_d    = state_q;
		fill_d     = fill_q;
		len_d      = len_q;
		ovf_d      = ovf_q;
		ptr_d      = ptr_q;
		k_d        = k_q;
		match_d    = match_q;
		entry_d    = entry_q;
		res_off_d  = res_off_q;
		res_st_d   = res_st_q;
		res_clr_d  = res_clr_q;
		n_d        = n_q;
		pend_d     = pend_q;
		pend_vld_d = pend_vld_q;

		pool_req       = '0;
		stg_req        = '0;
		emit           = 1'b0;
		res            = '0;
		res.last       = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (operation)
						sip_pkg::OP_PUSH: begin
							if (character != 8'd0) begin
								if (len_q < sip_pkg::LEN_W'(sip_pkg::MAX_NAME_LEN)) begin
									stg_req.we    = 1'b1;
									stg_req.addr  = len_q[sip_pkg::STG_AW-1:0];
									stg_req.wdata = character;
									len_d         = len_q + sip_pkg::LEN_W'(1);
								end else begin
									ovf_d = 1'b1;
								end
							end
							if (end_of_name) begin
								if (ovf_next) begin
									res_off_d = sip_pkg::NONE_OFFSET;
									res_st_d  = sip_pkg::ST_TOO_LONG;
									res_clr_d = 1'b1;
									state_d   = S_RESULT;
								end else begin
									ptr_d   = '0;
									k_d     = '0;
									match_d = 1'b1;
									entry_d = '0;
									state_d = S_SCAN_RD;
								end
							end
						end
						sip_pkg::OP_READ: begin
							if (read_empty) begin
								res_off_d = '0;
								res_st_d  = sip_pkg::ST_FOUND;
								res_clr_d = 1'b0;
								state_d   = S_RESULT;
							end else begin
								pool_req.re   = 1'b1;
								pool_req.addr = read_offset[sip_pkg::POOL_AW-1:0];
								ptr_d         = sip_pkg::FILL_W'(read_offset);
								n_d           = '0;
								pend_vld_d    = 1'b0;
								state_d       = S_RD_CHK;
							end
						end
						sip_pkg::OP_CLEAR: begin
							fill_d = '0;
							len_d  = '0;
							ovf_d  = 1'b0;
						end
						default: begin
						end
					endcase
				end
			end

			S_SCAN_RD: begin
				if (ptr_q == fill_q) begin
					// no stored match: append if it fits
					if (no_room) begin
						res_off_d = sip_pkg::NONE_OFFSET;
						res_st_d  = sip_pkg::ST_FULL;
						res_clr_d = 1'b1;
						state_d   = S_RESULT;
					end else begin
						k_d     = '0;
						state_d = S_APP_RD;
					end
				end else begin
					pool_req.re   = 1'b1;
					pool_req.addr = ptr_q[sip_pkg::POOL_AW-1:0];
					stg_req.re    = (k_q < len_q);
					stg_req.addr  = k_q[sip_pkg::STG_AW-1:0];
					state_d       = S_SCAN_CMP;
				end
			end

			S_SCAN_CMP: begin
				if (pool_rdata == 8'd0) begin
					if (match_q && (k_q == len_q)) begin
						res_off_d = sip_pkg::OFF_W'(entry_q);
						res_st_d  = sip_pkg::ST_FOUND;
						res_clr_d = 1'b1;
						state_d   = S_RESULT;
					end else begin
						entry_d = ptr_inc[sip_pkg::POOL_AW-1:0];
						k_d     = '0;
						match_d = 1'b1;
						ptr_d   = ptr_inc;
						state_d = S_SCAN_RD;
					end
				end else begin
					if ((k_q >= len_q) || (pool_rdata != stg_rdata)) begin
						match_d = 1'b0;
					end
					k_d     = k_q + sip_pkg::LEN_W'(1);
					ptr_d   = ptr_inc;
					state_d = S_SCAN_RD;
				end
			end

			S_APP_RD: begin
				if (k_q == len_q) begin
					// terminating nul closes the new entry
					pool_req.we    = 1'b1;
					pool_req.addr  = sip_pkg::POOL_AW'(fill_q + sip_pkg::FILL_W'(len_q));
					pool_req.wdata = 8'd0;
					fill_d         = need_end[sip_pkg::FILL_W-1:0];
					res_off_d      = sip_pkg::OFF_W'(fill_q);
					res_st_d       = sip_pkg::ST_ADDED;
					res_clr_d      = 1'b1;
					state_d        = S_RESULT;
				end else begin
					stg_req.re   = 1'b1;
					stg_req.addr = k_q[sip_pkg::STG_AW-1:0];
					state_d      = S_APP_WR;
				end
			end

			S_APP_WR: begin
				pool_req.we    = 1'b1;
				pool_req.addr  = sip_pkg::POOL_AW'(fill_q + sip_pkg::FILL_W'(k_q));
				pool_req.wdata = stg_rdata;
				k_d            = k_q + sip_pkg::LEN_W'(1);
				state_d        = S_APP_RD;
			end

			S_RESULT: begin
				if (can_emit) begin
					emit       = 1'b1;
					res.offset = res_off_q;
					res.status = res_st_q;
					if (res_clr_q) begin
						len_d = '0;
						ovf_d = 1'b0;
					end
					state_d = S_IDLE;
				end
			end

			S_RD_CHK: begin
				if (pool_rdata == 8'd0) begin
					if (can_emit) begin
						emit           = 1'b1;
						res.read_char  = pend_vld_q ? pend_q : 8'd0;
						res.char_valid = pend_vld_q;
						state_d        = S_IDLE;
					end
				end else if (!pend_vld_q || can_emit) begin
					// previous character is known not to be the final one
					if (pend_vld_q) begin
						emit           = 1'b1;
						res.read_char  = pend_q;
						res.char_valid = 1'b1;
						res.last       = 1'b0;
					end
					pend_d     = pool_rdata;
					pend_vld_d = 1'b1;
					n_d        = n_inc;
					ptr_d      = ptr_inc;
					if ((ptr_inc == fill_q) ||
						(n_inc == sip_pkg::LEN_W'(sip_pkg::MAX_NAME_LEN))) begin
						state_d = S_RD_LAST;
					end else begin
						pool_req.re   = 1'b1;
						pool_req.addr = ptr_inc[sip_pkg::POOL_AW-1:0];
						state_d       = S_RD_CHK;
					end
				end
			end

			S_RD_LAST: begin
				if (can_emit) begin
					emit           = 1'b1;
					res.read_char  = pend_q;
					res.char_valid = 1'b1;
					state_d        = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			fill_q     <= '0;
			len_q      <= '0;
			ovf_q      <= 1'b0;
			pend_vld_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			fill_q     <= fill_d;
			len_q      <= len_d;
			ovf_q      <= ovf_d;
			pend_vld_q <= pend_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q     <= ptr_d;
		k_q       <= k_d;
		match_q   <= match_d;
		entry_q   <= entry_d;
		res_off_q <= res_off_d;
		res_st_q  <= res_st_d;
		res_clr_q <= res_clr_d;
		n_q       <= n_d;
		pend_q    <= pend_d;
	end

endmodule

// File: rtl/string_intern_pool.sv
`timescale 1ns / 1ps
// String intern pool: stores NUL-terminated names in a byte pool, deduplicated.
// Input channel (in_valid/in_ready): operation push takes one name character;
// the push with end_of_name set interns the staged name and returns one result
// (offset, status). Operation read streams the string at read_offset as one
// result per character, last on the final one; an empty or invalid read gives
// one result with char_valid low. Operation clear empties the pool, no result.
// Output channel (out_valid/out_ready) is a single output register.
// A push without end_of_name or a clear leaves the engine idle. An intern,
// unless the name is too long, walks the pool through its single-port memory
// one stored byte at a time, each read followed by a compare, up to the
// matching entry or to the fill level; a new name then appends one character
// at a time, a staging read followed by a pool write, and closes with a
// terminating nul, and the result then goes to the output register. A read
// issues its first pool read, then streams its characters and closes.
// Only one transaction is in flight; in_ready is low until it has finished.
// When the receiver stalls, the engine holds its memory read data and waits.
// Reset clears the fill level and the staged name; no clearing pass is needed
// because pool bytes at or beyond the fill level are never read.

module string_intern_pool (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [7:0]  character,
	input  logic        end_of_name,
	input  logic [15:0] read_offset,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] offset,
	output logic [1:0]  status,
	output logic [7:0]  read_char,
	output logic        char_valid,
	output logic        last
);

	sip_pkg::pool_req_t pool_req;
	sip_pkg::stg_req_t  stg_req;
	sip_pkg::result_t   res;
	sip_pkg::result_t   res_q;
	logic [7:0]         pool_rdata;
	logic [7:0]         stg_rdata;
	logic               can_emit;
	logic               emit;

	sip_ram #(
		.DEPTH (sip_pkg::POOL_BYTES),
		.WIDTH (8)
	) u_pool (
		.clk   (clk),
		.re    (pool_req.re),
		.we    (pool_req.we),
		.addr  (pool_req.addr),
		.wdata (pool_req.wdata),
		.rdata (pool_rdata)
	);

	sip_ram #(
		.DEPTH (sip_pkg::MAX_NAME_LEN),
		.WIDTH (8)
	) u_staging (
		.clk   (clk),
		.re    (stg_req.re),
		.we    (stg_req.we),
		.addr  (stg_req.addr),
		.wdata (stg_req.wdata),
		.rdata (stg_rdata)
	);

	sip_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.character   (character),
		.end_of_name (end_of_name),
		.read_offset (read_offset),
		.pool_req    (pool_req),
		.pool_rdata  (pool_rdata),
		.stg_req     (stg_req),
		.stg_rdata   (stg_rdata),
		.can_emit    (can_emit),
		.emit        (emit),
		.res         (res)
	);

	sip_outreg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (emit),
		.res       (res),
		.can_load  (can_emit),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	assign offset     = res_q.offset;
	assign status     = res_q.status;
	assign read_char  = res_q.read_char;
	assign char_valid = res_q.char_valid;
	assign last       = res_q.last;

`ifndef NO_ASSERTIONS
	a_char_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_valid |-> (status == sip_pkg::ST_FOUND) && (offset == 16'd0))
		else $error("read character carries nonzero offset or status");

	a_nochar_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !char_valid |-> last)
		else $error("result without character is not marked last");

	a_refused_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((status == sip_pkg::ST_FULL) || (status == sip_pkg::ST_TOO_LONG))
		|-> (offset == sip_pkg::NONE_OFFSET))
		else $error("refused name without none offset");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (operation == sip_pkg::OP_READ) |=> !in_ready)
		else $error("read transaction did not occupy the engine");
`endif

endmodule
